// ===== rtl/gadz_pkg.sv =====
// Shared types, constants and helper functions of the gamepad axis dead zone unit.
package gadz_pkg;

	localparam int FracBits    = 14;
	localparam int One         = 1 << FracBits;
	localparam int ValW        = 16;
	localparam int DivNW       = 30;
	localparam int DivDW       = 16;
	localparam int DivQW       = 15;
	localparam int DivStepsPer = 5;
	localparam int NumStages   = 13;
	// Smallest floor quotient whose scaled value by 1.001 exceeds full scale.
	localparam int CircSatQ    = ((One + 1) * 1000 - 500 + 1000) / 1001;

	localparam logic [1:0] ModeNone    = 2'd0;
	localparam logic [1:0] ModeIndep   = 2'd1;
	localparam logic [1:0] ChLeftStick = 2'd2;

	localparam logic [1:0] RegModes  = 2'd0;
	localparam logic [1:0] RegSizes  = 2'd1;
	localparam logic [1:0] RegLimits = 2'd2;

	localparam logic [63:0] LimitsReset = 64'h4000_4000_4000_4000;

	typedef struct packed {
		logic [1:0]             ch;
		logic [1:0]             mode;
		logic signed [ValW-1:0] x;
		logic signed [ValW-1:0] y;
		logic [ValW-1:0]        lensq;
		logic [1:0]             in_zone;
		logic [1:0]             dzero;
		logic [1:0]             neg;
		logic signed [ValW-1:0] t0;
		logic signed [ValW-1:0] t1;
		logic                   circ_on;
	} side_t;

	// Trigger level scaled to round(level / 255) in Q2.14. Since 16384 is 64*255 + 64,
	// the result is 64*level plus floor((64*level + 127) / 255), and that small
	// quotient comes from the shift-and-add form (w + (w >> 8) + 1) >> 8.
	function automatic logic [14:0] trig_scale(input logic [7:0] lvl);
		logic [14:0] w;
		logic [16:0] t;
		w = {1'b0, lvl, 6'b0} + 15'd127;
		t = {2'b0, w} + {10'b0, w[14:8]} + 17'd1;
		return {1'b0, lvl, 6'b0} + {7'b0, t[15:8]};
	endfunction

	// floor(w / 1000) for w below 17000, as a count of passed thresholds.
	function automatic logic [4:0] div1000(input logic [14:0] w);
		logic [4:0] cnt;
		cnt = '0;
		for (int k = 1; k <= 16; k++) begin
			if (w >= 15'(k * 1000))
				cnt = cnt + 5'd1;
		end
		return cnt;
	endfunction

endpackage

// ===== rtl/gadz_if.sv =====
// Valid/ready channel interfaces for input samples and conditioned results.
interface gadz_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        channel;
	logic signed [15:0] raw_x;
	logic signed [15:0] raw_y;

	modport source(output valid, channel, raw_x, raw_y, input ready);
	modport sink(input valid, channel, raw_x, raw_y, output ready);
endinterface

interface gadz_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        which_channel;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;

	modport source(output valid, which_channel, out_x, out_y, input ready);
	modport sink(input valid, which_channel, out_x, out_y, output ready);
endinterface

// ===== rtl/gadz_front.sv =====
// Front stages: axis mapping, squares, squared length and dead zone divider setup.
module gadz_front import gadz_pkg::*; (
	input  logic                   clk,
	input  logic [3:0]             en,
	input  logic [1:0]             channel,
	input  logic signed [15:0]     raw_x,
	input  logic signed [15:0]     raw_y,
	input  logic [7:0]             zone_modes,
	input  logic [63:0]            zone_sizes,
	input  logic [63:0]            zone_limits,
	output side_t                  side_s4,
	output logic [DivNW-1:0]       n0_s4,
	output logic [DivNW-1:0]       n1_s4,
	output logic [DivDW-1:0]       d0_s4,
	output logic [DivDW-1:0]       d1_s4
);

	typedef struct packed {
		logic             in_zone;
		logic             dzero;
		logic             neg;
		logic [DivNW-1:0] n;
		logic [DivDW-1:0] d;
	} setup_t;

	// Stick axis mapped to round((2*raw+1) / 65535) in Q2.14.
	function automatic logic signed [15:0] stick_map(input logic signed [15:0] r);
		logic [14:0] m;
		logic [30:0] nn;
		logic [14:0] a;
		logic [16:0] ab;
		logic [14:0] q;
		m  = r[15] ? ~r[14:0] : r[14:0];
		nn = {m, 1'b1, 14'b0} + 31'd32767;
		a  = nn[30:16];
		ab = {2'b0, a} + {1'b0, nn[15:0]};
		q  = a + 15'(ab >= 17'd65535);
		return r[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic setup_t lane_setup(input logic signed [16:0] v,
			input logic [15:0] s, input logic [15:0] m);
		setup_t          o;
		logic signed [17:0] vs;
		logic signed [17:0] ss;
		logic signed [17:0] dd;
		logic signed [16:0] den;
		logic [17:0]     add;
		logic [16:0]     aden;
		vs        = {v[16], v};
		ss        = $signed({2'b0, s});
		dd        = (vs > ss) ? vs - ss : vs + ss;
		den       = $signed({1'b0, m}) - $signed({1'b0, s});
		add       = dd[17] ? 18'(-dd) : 18'(dd);
		aden      = den[16] ? 17'(-den) : 17'(den);
		o.in_zone = (vs >= -ss) && (vs <= ss);
		o.dzero   = (den == '0);
		o.neg     = dd[17] ^ den[16];
		o.n       = {add[15:0], {FracBits{1'b0}}} + DivNW'(aden[15:0] >> 1);
		o.d       = aden[15:0];
		return o;
	endfunction

	logic [1:0]         ch_s1, ch_s2, ch_s3;
	logic [1:0]         mode_s1, mode_s2, mode_s3;
	logic [15:0]        size_s1, size_s2, size_s3;
	logic [15:0]        lim_s1, lim_s2, lim_s3;
	logic signed [15:0] x_s1, x_s2, x_s3;
	logic signed [15:0] y_s1, y_s2, y_s3;
	logic [28:0]        sqx_s2, sqy_s2;
	logic [15:0]        lensq_s3;

	logic               trig;
	logic [7:0]         lvl;
	logic [15:0]        ax1, ay1;
	logic [29:0]        sqsum;
	logic signed [16:0] v0;
	setup_t             su0, su1;

	assign trig = (channel < ChLeftStick);
	assign lvl  = raw_x[15] ? 8'd0 : ((|raw_x[14:8]) ? 8'hFF : raw_x[7:0]);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ch_s1   <= channel;
			mode_s1 <= zone_modes[{channel, 1'b0} +: 2];
			size_s1 <= zone_sizes[{channel, 4'b0} +: 16];
			lim_s1  <= zone_limits[{channel, 4'b0} +: 16];
			x_s1    <= trig ? $signed({1'b0, trig_scale(lvl)}) : stick_map(raw_x);
			y_s1    <= trig ? 16'sd0 : stick_map(raw_y);
		end
	end

	assign ax1 = x_s1[15] ? 16'(-x_s1) : 16'(x_s1);
	assign ay1 = y_s1[15] ? 16'(-y_s1) : 16'(y_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ch_s2   <= ch_s1;
			mode_s2 <= mode_s1;
			size_s2 <= size_s1;
			lim_s2  <= lim_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			sqx_s2  <= 29'(ax1[14:0] * ax1[14:0]);
			sqy_s2  <= 29'(ay1[14:0] * ay1[14:0]);
		end
	end

	assign sqsum = {1'b0, sqx_s2} + {1'b0, sqy_s2} + 30'(One >> 1);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ch_s3    <= ch_s2;
			mode_s3  <= mode_s2;
			size_s3  <= size_s2;
			lim_s3   <= lim_s2;
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			lensq_s3 <= 16'(sqsum >> FracBits);
		end
	end

	// For sticks in circular mode lane zero works on the squared length instead of X.
	// Triggers always apply the scalar rule to their own value.
	assign v0  = (mode_s3[1] && (ch_s3 >= ChLeftStick)) ? $signed({1'b0, lensq_s3})
		: 17'(x_s3);
	assign su0 = lane_setup(v0, size_s3, lim_s3);
	assign su1 = lane_setup(17'(y_s3), size_s3, lim_s3);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			side_s4.ch      <= ch_s3;
			side_s4.mode    <= mode_s3;
			side_s4.x       <= x_s3;
			side_s4.y       <= y_s3;
			side_s4.lensq   <= lensq_s3;
			side_s4.in_zone <= {su1.in_zone, su0.in_zone};
			side_s4.dzero   <= {su1.dzero, su0.dzero};
			side_s4.neg     <= {su1.neg, su0.neg};
			side_s4.t0      <= '0;
			side_s4.t1      <= '0;
			side_s4.circ_on <= 1'b0;
			n0_s4           <= su0.n;
			n1_s4           <= su1.n;
			d0_s4           <= su0.d;
			d1_s4           <= su1.d;
		end
	end

endmodule

// ===== rtl/gadz_div.sv =====
// Three-stage restoring divider with a 15-bit quotient and an overflow flag.
module gadz_div import gadz_pkg::*; (
	input  logic             clk,
	input  logic [2:0]       en,
	input  logic [DivNW-1:0] n,
	input  logic [DivDW-1:0] d,
	output logic [DivQW-1:0] q,
	output logic             sat
);

	typedef struct packed {
		logic [DivDW-1:0] rem;
		logic [DivQW-1:0] nlo;
		logic [DivQW-1:0] q;
		logic [DivDW-1:0] d;
		logic             sat;
	} div_t;

	function automatic div_t advance(input div_t a);
		div_t           o;
		logic [DivDW:0] t;
		logic           ge;
		o = a;
		for (int i = 0; i < DivStepsPer; i++) begin
			t     = {o.rem, o.nlo[DivQW-1]};
			ge    = (t >= {1'b0, o.d});
			o.nlo = o.nlo << 1;
			o.q   = {o.q[DivQW-2:0], ge};
			o.rem = ge ? DivDW'(t - {1'b0, o.d}) : t[DivDW-1:0];
		end
		return o;
	endfunction

	div_t init, st_s1, st_s2, st_s3;

	always_comb begin
		init.rem = {1'b0, n[DivNW-1:DivQW]};
		init.nlo = n[DivQW-1:0];
		init.q   = '0;
		init.d   = d;
		// A quotient of 2^15 or more is beyond full scale for every user.
		init.sat = ({1'b0, n[DivNW-1:DivQW]} >= d);
	end

	always_ff @(posedge clk) begin
		if (en[0])
			st_s1 <= advance(init);
		if (en[1])
			st_s2 <= advance(st_s1);
		if (en[2])
			st_s3 <= advance(st_s2);
	end

	assign q   = st_s3.q;
	assign sat = st_s3.sat;

endmodule

// ===== rtl/gadz_mid.sv =====
// Middle stages: dead zone results and the circular scaling products.
module gadz_mid import gadz_pkg::*; (
	input  logic             clk,
	input  logic [1:0]       en,
	input  side_t            side_s7,
	input  logic [DivQW-1:0] q0,
	input  logic             sat0,
	input  logic [DivQW-1:0] q1,
	input  logic             sat1,
	output side_t            side_s9,
	output logic [DivNW-1:0] nx_s9,
	output logic [DivNW-1:0] ny_s9,
	output logic [DivDW-1:0] dl_s9
);

	function automatic logic signed [15:0] finish(input logic [DivQW-1:0] q, input logic sat,
			input logic in_zone, input logic dzero, input logic neg);
		logic signed [15:0] mag;
		mag = (sat || dzero || (q > DivQW'(One))) ? 16'(One) : $signed({1'b0, q});
		if (in_zone)
			return 16'sd0;
		return neg ? -mag : mag;
	endfunction

	side_t       side_s8, nxt8, nxt9;
	logic [15:0] ax8, ay8;

	always_comb begin
		nxt8    = side_s7;
		nxt8.t0 = finish(q0, sat0, side_s7.in_zone[0], side_s7.dzero[0], side_s7.neg[0]);
		nxt8.t1 = finish(q1, sat1, side_s7.in_zone[1], side_s7.dzero[1], side_s7.neg[1]);
	end

	always_comb begin
		nxt9         = side_s8;
		nxt9.circ_on = !side_s8.t0[15] && (side_s8.t0 != '0) && (side_s8.lensq != '0);
	end

	assign ax8 = side_s8.x[15] ? 16'(-side_s8.x) : 16'(side_s8.x);
	assign ay8 = side_s8.y[15] ? 16'(-side_s8.y) : 16'(side_s8.y);

	always_ff @(posedge clk) begin
		if (en[0])
			side_s8 <= nxt8;
		if (en[1]) begin
			side_s9 <= nxt9;
			nx_s9   <= DivNW'(ax8[14:0] * side_s8.t0[14:0]);
			ny_s9   <= DivNW'(ay8[14:0] * side_s8.t0[14:0]);
			dl_s9   <= side_s8.lensq;
		end
	end

endmodule

// ===== rtl/gadz_out.sv =====
// Output stage: circular axis scaling, mode selection and the result register.
module gadz_out import gadz_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  side_t              side_s12,
	input  logic [DivQW-1:0]   qx,
	input  logic               satx,
	input  logic [DivQW-1:0]   qy,
	input  logic               saty,
	output logic [1:0]         which_channel,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y
);

	// Scale a floor quotient by 1.001 with rounding, clamp to 1.0, apply the sign.
	function automatic logic signed [15:0] circ_axis(input logic [DivQW-1:0] q,
			input logic sat, input logic neg);
		logic [15:0] r;
		if (sat || (q >= DivQW'(CircSatQ)))
			r = 16'(One);
		else
			r = {1'b0, q} + 16'(div1000(q + 15'd500));
		return neg ? -$signed(r) : $signed(r);
	endfunction

	logic signed [15:0] cx, cy, ox, oy;

	assign cx = circ_axis(qx, satx, side_s12.x[15]);
	assign cy = circ_axis(qy, saty, side_s12.y[15]);

	always_comb begin
		ox = '0;
		oy = '0;
		if (side_s12.ch < ChLeftStick) begin
			ox = (side_s12.mode == ModeNone) ? side_s12.x : side_s12.t0;
		end else begin
			unique case (side_s12.mode)
				ModeNone: begin
					ox = side_s12.x;
					oy = side_s12.y;
				end
				ModeIndep: begin
					ox = side_s12.t0;
					oy = side_s12.t1;
				end
				default: begin
					ox = side_s12.circ_on ? cx : 16'sd0;
					oy = side_s12.circ_on ? cy : 16'sd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			which_channel <= side_s12.ch;
			out_x         <= ox;
			out_y         <= oy;
		end
	end

endmodule

// ===== rtl/gamepad_axis_dead_zone_unit.sv =====
// Top level of the gamepad axis dead zone unit: register port, pipeline control, datapath.
//
// Usage: each transfer on the sample channel carries one channel number and its raw
// X and Y values; exactly one transfer on the result channel follows, in order, with
// the conditioned values in signed Q2.14 and the channel number echoed. Triggers
// (channels 0 and 1) scale the level by 1/255, sticks map each axis to about
// raw/32768, then the channel's dead zone mode (none, independent or circular)
// from the register port is applied.
// The pipeline takes one sample in every cycle unless the receiver stalls; its depth is
// set by two chains of three-stage 15-bit dividers, one for the dead zone and one for
// circular scaling. Registers are written over the APB-style port at byte addresses 0
// (modes), 8 (sizes) and 16 (full scale values); the user must write them only while no
// sample is in flight, and the block itself does not enforce this. Reset clears all
// valid bits and loads sizes to zero, modes to none and every full scale value to 1.0.
// When the receiver stalls, the last stage holds its result and each stage upstream
// keeps filling empty slots; sample ready falls only once every stage holds an item, so
// nothing is lost or repeated.
module gamepad_axis_dead_zone_unit import gadz_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	gadz_in_if.sink      sample,
	gadz_out_if.source   result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [7:0]  zone_modes_q;
	logic [63:0] zone_sizes_q;
	logic [63:0] zone_limits_q;
	logic [1:0]  reg_idx;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_modes_q  <= '0;
			zone_sizes_q  <= '0;
			zone_limits_q <= LimitsReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegModes:  zone_modes_q  <= pwdata[7:0];
				RegSizes:  zone_sizes_q  <= pwdata;
				RegLimits: zone_limits_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegModes:  prdata = {56'b0, zone_modes_q};
			RegSizes:  prdata = zone_sizes_q;
			RegLimits: prdata = zone_limits_q;
			default:   prdata = '0;
		endcase
	end

	// Each stage advances when it is empty or the stage after it advances.
	logic [NumStages:1]   vld_q;
	logic [NumStages+1:1] en;

	always_comb begin
		en[NumStages+1] = result.ready;
		for (int k = NumStages; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= sample.valid;
			for (int k = 2; k <= NumStages; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign sample.ready = en[1];
	assign result.valid = vld_q[NumStages];

	side_t            side_s4, side_s5, side_s6, side_s7;
	side_t            side_s9, side_s10, side_s11, side_s12;
	logic [DivNW-1:0] n0_s4, n1_s4, nx_s9, ny_s9;
	logic [DivDW-1:0] d0_s4, d1_s4, dl_s9;
	logic [DivQW-1:0] q0, q1, qx, qy;
	logic             sat0, sat1, satx, saty;

	gadz_front u_front (
		.clk         (clk),
		.en          (en[4:1]),
		.channel     (sample.channel),
		.raw_x       (sample.raw_x),
		.raw_y       (sample.raw_y),
		.zone_modes  (zone_modes_q),
		.zone_sizes  (zone_sizes_q),
		.zone_limits (zone_limits_q),
		.side_s4     (side_s4),
		.n0_s4       (n0_s4),
		.n1_s4       (n1_s4),
		.d0_s4       (d0_s4),
		.d1_s4       (d1_s4)
	);

	gadz_div u_div_zone0 (.clk(clk), .en(en[7:5]), .n(n0_s4), .d(d0_s4), .q(q0), .sat(sat0));
	gadz_div u_div_zone1 (.clk(clk), .en(en[7:5]), .n(n1_s4), .d(d1_s4), .q(q1), .sat(sat1));

	always_ff @(posedge clk) begin
		if (en[5])
			side_s5 <= side_s4;
		if (en[6])
			side_s6 <= side_s5;
		if (en[7])
			side_s7 <= side_s6;
		if (en[10])
			side_s10 <= side_s9;
		if (en[11])
			side_s11 <= side_s10;
		if (en[12])
			side_s12 <= side_s11;
	end

	gadz_mid u_mid (
		.clk     (clk),
		.en      (en[9:8]),
		.side_s7 (side_s7),
		.q0      (q0),
		.sat0    (sat0),
		.q1      (q1),
		.sat1    (sat1),
		.side_s9 (side_s9),
		.nx_s9   (nx_s9),
		.ny_s9   (ny_s9),
		.dl_s9   (dl_s9)
	);

	gadz_div u_div_circx (.clk(clk), .en(en[12:10]), .n(nx_s9), .d(dl_s9), .q(qx), .sat(satx));
	gadz_div u_div_circy (.clk(clk), .en(en[12:10]), .n(ny_s9), .d(dl_s9), .q(qy), .sat(saty));

	gadz_out u_out (
		.clk           (clk),
		.en            (en[NumStages]),
		.side_s12      (side_s12),
		.qx            (qx),
		.satx          (satx),
		.qy            (qy),
		.saty          (saty),
		.which_channel (result.which_channel),
		.out_x         (result.out_x),
		.out_y         (result.out_y)
	);

`ifndef SYNTH
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (&vld_q))
		else $error("sample ready low while a pipeline slot is empty");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.out_x <= $signed(16'(One)))
			&& (result.out_x >= -$signed(16'(One)))
			&& (result.out_y <= $signed(16'(One)))
			&& (result.out_y >= -$signed(16'(One))))
		else $error("result beyond full scale");

	a_trigger_y_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.which_channel < ChLeftStick) |-> (result.out_y == '0))
		else $error("trigger result with nonzero Y");

	a_stall_keeps_full: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> vld_q[NumStages])
		else $error("stalled result slot lost its item");
`endif

endmodule
